/* hdl/dpb_pkg.sv */
// ----------------------------------------------------------------------------
// Depth pixel back-projection package
// Shared widths, word types, register codes and the coordinate saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dpb_pkg;

  // Default image size
  localparam int unsigned ImageWidth  = 640;
  localparam int unsigned ImageHeight = 368;

  // Fixed field widths
  localparam int unsigned KW    = 32;  // inverse intrinsic coefficient, Q2.30
  localparam int unsigned DEPW  = 24;  // inverse depth, Q8.16
  localparam int unsigned PRODW = 43;  // coefficient times pixel index
  localparam int unsigned RAYW  = 44;  // ray component, Q.30
  localparam int unsigned MAGW  = 43;  // ray magnitude
  localparam int unsigned DIVW  = 45;  // rounded dividend and quotient
  localparam int unsigned CIW   = 3;   // register index width

  // Configuration register codes
  typedef enum logic [CIW-1:0] {
    CfgK00      = 3'd0,
    CfgK01      = 3'd1,
    CfgK02      = 3'd2,
    CfgK10      = 3'd3,
    CfgK11      = 3'd4,
    CfgK12      = 3'd5,
    CfgVarLimit = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic        [9:0]  column;
    logic        [8:0]  row;
    logic        [23:0] inverse_depth;
    logic signed [23:0] depth_variance;
    logic signed [15:0] intensity;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] point_intensity;
    logic               saturated;
  } out_word_t;

  typedef struct packed {
    logic [CIW-1:0] index;
    logic [31:0]    wdata;
  } cfg_word_t;

  // Flags that travel beside the divider
  typedef struct packed {
    logic               valid;
    logic               neg_x;
    logic               neg_y;
    logic               zero_x;
    logic               zero_y;
    logic               dzero;
    logic signed [15:0] intensity;
  } side_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } coord_t;

  // Turn an unsigned rounded quotient into a saturated signed Q16.16 value.
  function automatic coord_t sat_coord(input logic [DIVW-1:0] quo, input logic neg,
                                       input logic rzero, input logic dzero);
    coord_t res;
    res.sat = 1'b0;
    if (dzero) begin
      res.sat = 1'b1;
      if (rzero) begin
        res.value = 32'h0000_0000;
      end else if (neg) begin
        res.value = 32'h8000_0000;
      end else begin
        res.value = 32'h7FFF_FFFF;
      end
    end else if (neg) begin
      if (quo > DIVW'(33'h0_8000_0000)) begin
        res.value = 32'h8000_0000;
        res.sat   = 1'b1;
      end else begin
        res.value = 32'(~quo + DIVW'(1));
      end
    end else begin
      if (quo > DIVW'(32'h7FFF_FFFF)) begin
        res.value = 32'h7FFF_FFFF;
        res.sat   = 1'b1;
      end else begin
        res.value = quo[31:0];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hdl/dpb_stream_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one word of type T per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dpb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/depth_pixel_backprojection_top.sv */
// ----------------------------------------------------------------------------
// Depth pixel back-projection, top level
// From pixel word to point word: three ray stages, 45
// divider stages (one quotient bit each) and the output register.
// Throughput one pixel per cycle; the whole pipeline holds while a point
// word waits at the output. Reset clears all valid bits and loads the
// identity intrinsics and the open variance limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module depth_pixel_backprojection_top #(
  parameter int unsigned IMAGE_WIDTH  = dpb_pkg::ImageWidth,
  parameter int unsigned IMAGE_HEIGHT = dpb_pkg::ImageHeight
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  dpb_stream_if.sink   cfg_i,
  dpb_stream_if.sink   pix_i,
  dpb_stream_if.source pt_o
);
  import dpb_pkg::*;

  logic signed [KW-1:0] k    [6];
  logic [22:0]          var_limit;
  logic                 en;
  side_t                ray_side;
  side_t                side_q [DIVW];
  logic [DIVW-1:0]      num_x, num_y, num_z;
  logic [DIVW-1:0]      quo_x, quo_y, quo_z;
  logic [DEPW-1:0]      den;
  coord_t               cx, cy, cz;
  side_t                last;
  logic                 out_valid_q;
  out_word_t            out_q;

  // The pipeline advances whenever the output register is free or drained.
  assign en          = !out_valid_q || pt_o.ready;
  assign pix_i.ready = en;

  dpb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .k_o         (k),
    .var_limit_o (var_limit)
  );

  dpb_ray #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_ray (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (pix_i.valid),
    .pix_i       (pix_i.data),
    .k_i         (k),
    .var_limit_i (var_limit),
    .side_o      (ray_side),
    .num_x_o     (num_x),
    .num_y_o     (num_y),
    .num_z_o     (num_z),
    .den_o       (den)
  );

  dpb_div u_div_x (.clk_i(clk_i), .en_i(en), .num_i(num_x), .den_i(den), .quo_o(quo_x));
  dpb_div u_div_y (.clk_i(clk_i), .en_i(en), .num_i(num_y), .den_i(den), .quo_o(quo_y));
  dpb_div u_div_z (.clk_i(clk_i), .en_i(en), .num_i(num_z), .den_i(den), .quo_o(quo_z));

  // Flags and intensity ride alongside the divider lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIVW; s++) begin
        side_q[s] <= '0;
      end
    end else if (en) begin
      side_q[0] <= ray_side;
      for (int s = 1; s < DIVW; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Saturate the three coordinates.
  always_comb begin
    last = side_q[DIVW-1];
    cx   = sat_coord(quo_x, last.neg_x, last.zero_x, last.dzero);
    cy   = sat_coord(quo_y, last.neg_y, last.zero_y, last.dzero);
    cz   = sat_coord(quo_z, 1'b0, 1'b0, last.dzero);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.point_x         <= cx.value;
      out_q.point_y         <= cy.value;
      out_q.point_z         <= cz.value;
      out_q.point_intensity <= last.intensity;
      out_q.saturated       <= cx.sat | cy.sat | cz.sat;
    end
  end

  assign pt_o.valid = out_valid_q;
  assign pt_o.data  = out_q;

endmodule

`default_nettype wire

/* hdl/dpb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the two upper rows of the inverse intrinsics and the variance limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpb_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  dpb_stream_if.sink                           cfg_i,
  output logic signed [dpb_pkg::KW-1:0]        k_o [6],
  output logic        [22:0]                   var_limit_o
);
  import dpb_pkg::*;

  logic signed [KW-1:0] k_q [6];
  logic        [22:0]   var_limit_q;

  // Writes are always taken; an unknown index is ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q[0]      <= 32'sh4000_0000;
      k_q[1]      <= '0;
      k_q[2]      <= '0;
      k_q[3]      <= '0;
      k_q[4]      <= 32'sh4000_0000;
      k_q[5]      <= '0;
      var_limit_q <= 23'h7F_FFFF;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.data.index))
        CfgK00:      k_q[0] <= cfg_i.data.wdata;
        CfgK01:      k_q[1] <= cfg_i.data.wdata;
        CfgK02:      k_q[2] <= cfg_i.data.wdata;
        CfgK10:      k_q[3] <= cfg_i.data.wdata;
        CfgK11:      k_q[4] <= cfg_i.data.wdata;
        CfgK12:      k_q[5] <= cfg_i.data.wdata;
        CfgVarLimit: var_limit_q <= cfg_i.data.wdata[22:0];
        default: begin
        end
      endcase
    end
  end

  assign k_o         = k_q;
  assign var_limit_o = var_limit_q;

endmodule

`default_nettype wire

/* hdl/dpb_ray.sv */
// ----------------------------------------------------------------------------
// Ray front end
// Filters pixels, forms the ray in three stages and prepares the dividends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpb_ray #(
  parameter int unsigned IMAGE_WIDTH  = dpb_pkg::ImageWidth,
  parameter int unsigned IMAGE_HEIGHT = dpb_pkg::ImageHeight
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire dpb_pkg::in_word_t            pix_i,
  input  wire logic signed [dpb_pkg::KW-1:0] k_i [6],
  input  wire logic [22:0]                  var_limit_i,
  output dpb_pkg::side_t                    side_o,
  output logic [dpb_pkg::DIVW-1:0]          num_x_o,
  output logic [dpb_pkg::DIVW-1:0]          num_y_o,
  output logic [dpb_pkg::DIVW-1:0]          num_z_o,
  output logic [dpb_pkg::DEPW-1:0]          den_o
);
  import dpb_pkg::*;

  logic                    pass;
  logic                    v1_q, v2_q, v3_q;
  logic signed [PRODW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic signed [RAYW-1:0]  rx2_q, ry2_q;
  logic [DEPW-1:0]         dep1_q, dep2_q, dep3_q;
  logic signed [15:0]      int1_q, int2_q, int3_q;
  logic [MAGW-1:0]         mag_x, mag_y;
  logic                    nx3_q, ny3_q, zx3_q, zy3_q, dz3_q;
  logic [DIVW-1:0]         nxd_q, nyd_q, nzd_q;

  // Pixel acceptance: inside the image, valid marks and variance in limit.
  always_comb begin
    pass = ({3'b000, pix_i.column} < 13'(IMAGE_WIDTH))
        && ({4'b0000, pix_i.row} < 13'(IMAGE_HEIGHT))
        && !pix_i.depth_variance[23] && !pix_i.intensity[15]
        && (pix_i.depth_variance[22:0] <= var_limit_i);
  end

  // Magnitudes of the summed ray components.
  assign mag_x = rx2_q[RAYW-1] ? MAGW'(-rx2_q) : MAGW'(rx2_q);
  assign mag_y = ry2_q[RAYW-1] ? MAGW'(-ry2_q) : MAGW'(ry2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i & pass;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 1: the four products, formed at full product width.
      p00_q  <= PRODW'(k_i[0]) * PRODW'($signed({1'b0, pix_i.column}));
      p01_q  <= PRODW'(k_i[1]) * PRODW'($signed({2'b00, pix_i.row}));
      p10_q  <= PRODW'(k_i[3]) * PRODW'($signed({1'b0, pix_i.column}));
      p11_q  <= PRODW'(k_i[4]) * PRODW'($signed({2'b00, pix_i.row}));
      dep1_q <= pix_i.inverse_depth;
      int1_q <= pix_i.intensity;
      // Stage 2: ray sums with the constant column.
      rx2_q  <= RAYW'(p00_q) + RAYW'(p01_q) + RAYW'(k_i[2]);
      ry2_q  <= RAYW'(p10_q) + RAYW'(p11_q) + RAYW'(k_i[5]);
      dep2_q <= dep1_q;
      int2_q <= int1_q;
      // Stage 3: rounded dividends, 4*|R| + d/2.
      nx3_q  <= rx2_q[RAYW-1];
      ny3_q  <= ry2_q[RAYW-1];
      zx3_q  <= (rx2_q == '0);
      zy3_q  <= (ry2_q == '0);
      dz3_q  <= (dep2_q == '0);
      nxd_q  <= {mag_x, 2'b00} + DIVW'(dep2_q[DEPW-1:1]);
      nyd_q  <= {mag_y, 2'b00} + DIVW'(dep2_q[DEPW-1:1]);
      nzd_q  <= DIVW'(33'h1_0000_0000) + DIVW'(dep2_q[DEPW-1:1]);
      dep3_q <= dep2_q;
      int3_q <= int2_q;
    end
  end

  always_comb begin
    side_o.valid     = v3_q;
    side_o.neg_x     = nx3_q;
    side_o.neg_y     = ny3_q;
    side_o.zero_x    = zx3_q;
    side_o.zero_y    = zy3_q;
    side_o.dzero     = dz3_q;
    side_o.intensity = int3_q;
  end

  assign num_x_o = nxd_q;
  assign num_y_o = nyd_q;
  assign num_z_o = nzd_q;
  assign den_o   = dep3_q;

endmodule

`default_nettype wire

/* hdl/dpb_div.sv */
// ----------------------------------------------------------------------------
// Pipelined divider lane
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpb_div (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [dpb_pkg::DIVW-1:0]    num_i,
  input  wire logic [dpb_pkg::DEPW-1:0]    den_i,
  output logic [dpb_pkg::DIVW-1:0]         quo_o
);
  import dpb_pkg::*;

  logic [DEPW-1:0] rem_q [DIVW];
  logic [DIVW-1:0] num_q [DIVW];
  logic [DIVW-1:0] quo_q [DIVW];
  logic [DEPW-1:0] den_q [DIVW];

  for (genvar s = 0; s < DIVW; s++) begin : g_stage
    logic [DEPW-1:0] rem_in;
    logic [DIVW-1:0] num_in;
    logic [DIVW-1:0] quo_in;
    logic [DEPW-1:0] den_in;
    logic [DEPW:0]   trial;
    logic            ge;

    // Stage inputs: the lane input for the first bit, else the stage before.
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    // Bring down one dividend bit and try the subtraction.
    always_comb begin
      trial = {rem_in, num_in[DIVW-1]};
      ge    = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? DEPW'(trial - {1'b0, den_in}) : DEPW'(trial);
        num_q[s] <= {num_in[DIVW-2:0], 1'b0};
        quo_q[s] <= {quo_in[DIVW-2:0], ge};
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DIVW-1];

endmodule

`default_nettype wire

/* test/tb_depth_pixel_backprojection_top.sv */
// ----------------------------------------------------------------------------
// Depth pixel back-projection testbench
// Drives pixel words and register writes into the block and checks every point
// word against a local fixed point predictor, in order. A directed table covers
// the extremes first. Random phases then follow under several sets of
// intrinsics and variance limits, with idle and stall patterns on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_depth_pixel_backprojection_top;
  import dpb_pkg::*;

  localparam int unsigned PipeDrain  = 60;      // latency plus margin
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 200;
  localparam logic [CIW-1:0] CfgUnused = 3'd7;  // index past the register list

  typedef struct {
    in_word_t  pix;
    bit        typed;   // expected point typed in below
    bit        emits;
    out_word_t pt;
  } pix_row_t;

  logic clk_i;
  logic rst_ni;

  dpb_stream_if #(.T(cfg_word_t)) cfg_if ();
  dpb_stream_if #(.T(in_word_t))  pix_if ();
  dpb_stream_if #(.T(out_word_t)) pt_if ();

  depth_pixel_backprojection_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .pt_o   (pt_if)
  );

  // Local copy of the camera registers.
  logic signed [31:0] k_coef [6];
  logic [22:0]        var_limit;

  out_word_t   point_q [$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned send_pct;
  int unsigned recv_pct;
  int unsigned hold_req;
  pix_row_t    dir_tab [$];

  // Clock and run limit.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_depth_pixel_backprojection_top: FAIL");
      $finish;
    end
  end

  // Divide one ray component (Q.30) by the inverse depth and saturate to Q16.16.
  function automatic logic [31:0] ray_to_coord(input longint r, input longint unsigned d,
                                              inout bit sat);
    longint unsigned mag;
    longint unsigned q;
    mag = (r < 0) ? longint'(-r) : longint'(r);
    if (d == 0) begin
      sat = 1'b1;
      if (mag == 0) return 32'h0000_0000;
      return (r < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    q = (mag * 4 + d / 2) / d;
    if (r < 0) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  // Back-project one pixel under the current registers; returns 0 if dropped.
  function automatic bit backproject(input in_word_t p, output out_word_t pt);
    longint          rx;
    longint          ry;
    longint unsigned d;
    bit              sat;
    pt = '0;
    sat = 1'b0;
    if (p.column >= ImageWidth || p.row >= ImageHeight) return 1'b0;
    if (p.depth_variance < 0 || p.intensity < 0) return 1'b0;
    if (longint'(p.depth_variance) > longint'(var_limit)) return 1'b0;
    rx = longint'(k_coef[0]) * longint'(p.column) + longint'(k_coef[1]) * longint'(p.row)
         + longint'(k_coef[2]);
    ry = longint'(k_coef[3]) * longint'(p.column) + longint'(k_coef[4]) * longint'(p.row)
         + longint'(k_coef[5]);
    d = longint'(p.inverse_depth);
    pt.point_x = ray_to_coord(rx, d, sat);
    pt.point_y = ray_to_coord(ry, d, sat);
    pt.point_z = ray_to_coord(longint'(1) << 30, d, sat);
    pt.point_intensity = p.intensity;
    pt.saturated = sat;
    return 1'b1;
  endfunction

  function automatic in_word_t mk_pix(input int col, input int row, input int idep,
                                      input int var_q, input int inten);
    in_word_t w;
    w.column = col[9:0];
    w.row = row[8:0];
    w.inverse_depth = idep[23:0];
    w.depth_variance = var_q[23:0];
    w.intensity = inten[15:0];
    return w;
  endfunction

  function automatic out_word_t mk_pt(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic [15:0] inten,
                                      input logic sat);
    out_word_t o;
    o.point_x = x;
    o.point_y = y;
    o.point_z = z;
    o.point_intensity = inten;
    o.saturated = sat;
    return o;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at cycle %0d", field, got, want, cycle_cnt);
    err_cnt++;
  endtask

  // Check every accepted point word against the oldest expectation.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && pt_if.valid && pt_if.ready) begin
      if (point_q.size() == 0) begin
        report("unexpected word", pt_if.data.point_x, 32'h0);
      end else begin
        want = point_q.pop_front();
        if (pt_if.data.point_x !== want.point_x) report("x", pt_if.data.point_x, want.point_x);
        if (pt_if.data.point_y !== want.point_y) report("y", pt_if.data.point_y, want.point_y);
        if (pt_if.data.point_z !== want.point_z) report("z", pt_if.data.point_z, want.point_z);
        if (pt_if.data.point_intensity !== want.point_intensity)
          report("intensity", 32'(pt_if.data.point_intensity), 32'(want.point_intensity));
        if (pt_if.data.saturated !== want.saturated)
          report("saturated", 32'(pt_if.data.saturated), 32'(want.saturated));
      end
    end
  end

  // Receiver: random back-pressure, plus long holds on request.
  initial begin
    int unsigned hold_cnt;
    hold_cnt = 0;
    pt_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        pt_if.ready = 1'b0;
      end else begin
        pt_if.ready = ($urandom_range(99) >= recv_pct);
      end
    end
  end

  // Offer one pixel word; starts and ends on a falling edge.
  task automatic send_pixel(input pix_row_t r);
    out_word_t pt;
    while ($urandom_range(99) < send_pct) begin
      pix_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid = 1'b1;
    pix_if.data = r.pix;
    do @(posedge clk_i); while (!pix_if.ready);
    if (r.typed) begin
      if (r.emits) point_q.insert(point_q.size(), r.pt);
    end else if (backproject(r.pix, pt)) begin
      point_q.insert(point_q.size(), pt);
    end
    @(negedge clk_i);
  endtask

  // Wait until every point word has come and the pipeline is empty.
  task automatic settle();
    pix_if.valid = 1'b0;
    while (point_q.size() != 0) @(negedge clk_i);
    repeat (PipeDrain) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CIW-1:0] idx, input logic [31:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.data.index = idx;
    cfg_if.data.wdata = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx < CfgVarLimit) k_coef[idx] = val;
    else if (idx == CfgVarLimit) var_limit = val[22:0];
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Random pixel: mostly valid pixels, some raw noise.
  function automatic in_word_t rand_pixel();
    logic [95:0] raw;
    in_word_t    w;
    raw = {$urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    if ($urandom_range(99) < 85) begin
      w.column = 10'($urandom_range(ImageWidth - 1));
      w.row = 9'($urandom_range(ImageHeight - 1));
      case ($urandom_range(3))
        0: w.inverse_depth = 24'($urandom_range(255));
        1: w.inverse_depth = 24'($urandom_range(32'h3_0000, 32'h100));
        2: w.inverse_depth = (($urandom_range(9) == 0) ? 24'd0 : w.inverse_depth);
        default: ;
      endcase
      w.depth_variance = (var_limit == 0) ? 24'd0 :
                         24'($urandom_range(32'(var_limit) + (var_limit >> 4)));
      w.intensity[15] = 1'b0;
    end
    return w;
  endfunction

  task automatic rand_config(input int unsigned kind);
    logic [31:0] v;
    for (int i = 0; i <= int'(CfgVarLimit); i++) begin
      case (kind)
        0: v = (i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        1: v = (i % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default: begin
          if (i == 0 || i == 4) v = 32'h4000_0000 / $urandom_range(600, 300);
          else if (i == 2 || i == 5) v = -($urandom_range(32'h4000_0000));
          else v = $urandom_range(4095) - 2048;
          if ($urandom_range(3) == 0) v = $urandom;
        end
      endcase
      if (i == int'(CfgVarLimit)) begin
        if (kind == 0) v = 32'h0;
        else if (kind == 1) v = 32'h7F_FFFF;
        else v = $urandom_range(32'h7F_FFFF);
      end
      write_reg(i[CIW-1:0], v);
    end
  endtask

  // Main sequence.
  initial begin
    pix_row_t r;
    rst_ni = 1'b0;
    cycle_cnt = 0;
    err_cnt = 0;
    send_pct = 0;
    recv_pct = 0;
    hold_req = 0;
    pix_if.valid = 1'b0;
    pix_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    k_coef = '{32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h4000_0000, 32'h0};
    var_limit = 23'h7F_FFFF;

    // Directed table under the reset registers.
    dir_tab.insert(dir_tab.size(), '{mk_pix(0, 0, 32'h1_0000, 0, 0), 1, 1,
                   mk_pt(32'h0, 32'h0, 32'h1_0000, 16'h0, 1'b0)});
    dir_tab.insert(dir_tab.size(), '{mk_pix(5, 3, 0, 10, 100), 1, 1,
                   mk_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd100, 1'b1)});
    dir_tab.insert(dir_tab.size(), '{mk_pix(0, 0, 0, 0, 32767), 1, 1,
                   mk_pt(32'h0, 32'h0, 32'h7FFF_FFFF, 16'h7FFF, 1'b1)});
    dir_tab.insert(dir_tab.size(), '{mk_pix(639, 0, 1, 0, 1), 1, 1,
                   mk_pt(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 16'd1, 1'b1)});
    dir_tab.insert(dir_tab.size(),
                   '{mk_pix(639, 367, 32'hFF_FFFF, 32'h7F_FFFF, 5), 0, 0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_pix(1, 1, 32'h1_0000, -1, 5), 1, 0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_pix(1, 1, 32'h1_0000, -8388608, 5), 1, 0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_pix(1, 1, 32'h1_0000, 4, -1), 1, 0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_pix(1, 1, 32'h1_0000, 4, -32768), 1, 0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_pix(640, 1, 32'h1_0000, 4, 5), 1, 0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_pix(1023, 1, 32'h1_0000, 4, 5), 1, 0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_pix(1, 368, 32'h1_0000, 4, 5), 1, 0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_pix(1, 511, 32'h1_0000, 4, 5), 1, 0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_pix(320, 184, 32'h8000, 100, 77), 0, 0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_pix(2, 7, 3, 1, 1), 0, 0, '0});

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_pixel(dir_tab[i]);
    settle();

    // A write to an unused index must leave the registers alone.
    write_reg(CfgUnused, 32'hFFFF_FFFF);
    r = '{mk_pix(10, 20, 32'h1_0000, 3, 9), 0, 0, '0};
    send_pixel(r);
    settle();

    // Random phases, each under freshly written registers and one of three idle patterns.
    for (int ph = 0; ph < 4; ph++) begin
      rand_config((ph == 0) ? 2 : ph - 1);
      case (ph % 3)
        0: begin send_pct = 35; recv_pct = 86; end
        1: begin send_pct = 86; recv_pct = 35; end
        default: begin send_pct = 0; recv_pct = 0; end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 2 && n == 20) hold_req = 300;
        if (n == PhaseItems / 2) begin
          pix_if.valid = 1'b0;
          while (point_q.size() != 0) @(negedge clk_i);
        end
        r = '{rand_pixel(), 0, 0, '0};
        send_pixel(r);
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("tb_depth_pixel_backprojection_top: PASS");
    end else begin
      $display("tb_depth_pixel_backprojection_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* depth_pixel_backprojection_top.f */
hdl/dpb_pkg.sv
hdl/dpb_stream_if.sv
hdl/dpb_cfg_regs.sv
hdl/dpb_ray.sv
hdl/dpb_div.sv
hdl/depth_pixel_backprojection_top.sv
test/tb_depth_pixel_backprojection_top.sv
